@@ rtl/capture_period_frequency_meter_top_macros.svh @@
// Assertion macros for the capture period frequency meter.
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_TOP_MACROS_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CPFM_ASSERT_NOW(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpfm: check failed");
`define CPFM_ASSERT_NEXT(label, ck, rst_n, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpfm: check failed");
`else
`define CPFM_ASSERT_NOW(label, ck, rst_n, ante, cons)
`define CPFM_ASSERT_NEXT(label, ck, rst_n, ante, cons)
`endif
`endif

@@ rtl/cpfm_pkg.sv @@
// Shared constants and types for the capture period frequency meter.
package cpfm_pkg;
	localparam int TIME_W = 32;
	localparam int FREQ_W = 40;
	localparam int RATE_W = 24;
	localparam int CHANNELS_DEF = 2;
	localparam int FRACTION_BITS_DEF = 16;
	localparam logic [RATE_W-1:0] TICK_RATE_RESET = 24'd1000000;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage

@@ rtl/cpfm_div.sv @@
// Iterative restoring divider: (rate << FRACTION_BITS) / divisor, saturated to 40 bits.
module cpfm_div #(
	parameter int FRACTION_BITS = cpfm_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cpfm_pkg::RATE_W-1:0]     rate,
	input  logic [cpfm_pkg::TIME_W-1:0]     divisor,
	output cpfm_pkg::div_stat_t             stat,
	output logic [cpfm_pkg::FREQ_W-1:0]     quotient
);
	localparam int NUM_W = cpfm_pkg::RATE_W + FRACTION_BITS;
	localparam int QX_W = ((NUM_W > cpfm_pkg::FREQ_W) ? NUM_W : cpfm_pkg::FREQ_W) + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [NUM_W-1:0]              num_q;
	logic [cpfm_pkg::TIME_W-1:0]   div_q;
	logic [cpfm_pkg::TIME_W-1:0]   rem_q;
	logic [QX_W-1:0]               quo_q;
	logic [cpfm_pkg::TIME_W:0]     shifted;
	logic [cpfm_pkg::TIME_W:0]     diff;
	logic                          ge;
	logic                          sat;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign ge = shifted >= {1'b0, div_q};
	assign diff = shifted - {1'b0, div_q};
	assign sat = |quo_q[QX_W-1:cpfm_pkg::FREQ_W];
	assign quotient = sat ? '1 : quo_q[cpfm_pkg::FREQ_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_W'(rate) << FRACTION_BITS;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[cpfm_pkg::TIME_W-1:0] : shifted[cpfm_pkg::TIME_W-1:0];
			quo_q <= {quo_q[QX_W-2:0], ge};
		end
	end
endmodule

@@ rtl/cpfm_store.sv @@
// Per-channel last timestamp and held frequency registers.
module cpfm_store #(
	parameter int CHANNELS = cpfm_pkg::CHANNELS_DEF,
	parameter int IDX_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [IDX_W-1:0]              rd_idx,
	output logic [cpfm_pkg::TIME_W-1:0]   rd_time,
	output logic [cpfm_pkg::FREQ_W-1:0]   rd_freq,
	input  logic                          wr_en,
	input  logic [IDX_W-1:0]              wr_idx,
	input  logic [cpfm_pkg::TIME_W-1:0]   wr_time,
	input  logic [cpfm_pkg::FREQ_W-1:0]   wr_freq
);
	logic [cpfm_pkg::TIME_W-1:0] time_q [CHANNELS];
	logic [cpfm_pkg::FREQ_W-1:0] freq_q [CHANNELS];

	always_comb begin
		rd_time = '0;
		rd_freq = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (rd_idx == IDX_W'(i)) begin
				rd_time = time_q[i];
				rd_freq = freq_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				time_q[i] <= '0;
				freq_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (wr_en && wr_idx == IDX_W'(i)) begin
					time_q[i] <= wr_time;
					freq_q[i] <= wr_freq;
				end
			end
		end
	end
endmodule

@@ rtl/capture_period_frequency_meter_top.sv @@
// Top level of the capture period frequency meter: sequencer, output register.
//
//   channel  signals                                       direction
//   in       in_valid, in_stall, channel, capture_time     transaction in
//   out      out_valid, out_stall, out_channel, frequency,  transaction out
//            updated
//   cfg      cfg_wr_en, cfg_wr_data (tick_rate)            write only
//
// A transaction with a nonzero period goes from acceptance through ST_CALC and the
// bit-serial divider in ST_DIV to ST_WAIT, where it moves into the output register.
// Equal timestamps or an unused channel skip the divider, ST_CALC going to ST_WAIT.
// in_stall is high while an item is at work and while a finished result waits for
// out_stall to free the output register. Reset clears timestamps, frequencies and
// sets tick_rate to 1000000.
`include "capture_period_frequency_meter_top_macros.svh"
module capture_period_frequency_meter_top #(
	parameter int CHANNELS = cpfm_pkg::CHANNELS_DEF,
	parameter int FRACTION_BITS = cpfm_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          channel,
	input  logic [cpfm_pkg::TIME_W-1:0]   capture_time,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          out_channel,
	output logic [cpfm_pkg::FREQ_W-1:0]   frequency,
	output logic                          updated,
	input  logic                          cfg_wr_en,
	input  logic [cpfm_pkg::RATE_W-1:0]   cfg_wr_data
);
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	logic [1:0]                    state_q;
	logic [cpfm_pkg::RATE_W-1:0]   tick_rate_q;
	logic                          ch_q;
	logic [cpfm_pkg::TIME_W-1:0]   time_q;
	logic [cpfm_pkg::FREQ_W-1:0]   res_freq_q;
	logic                          res_upd_q;
	logic                          out_valid_q;
	logic                          out_ch_q;
	logic [cpfm_pkg::FREQ_W-1:0]   out_freq_q;
	logic                          out_upd_q;
	logic [IDX_W-1:0]              idx;
	logic [cpfm_pkg::TIME_W-1:0]   rd_time;
	logic [cpfm_pkg::FREQ_W-1:0]   rd_freq;
	logic [cpfm_pkg::TIME_W-1:0]   period;
	logic                          in_range;
	logic                          div_start;
	logic                          st_wr;
	logic                          out_free;
	cpfm_pkg::div_stat_t           div_stat;
	logic [cpfm_pkg::FREQ_W-1:0]   quotient;

	assign idx = IDX_W'(ch_q);
	assign in_range = (CHANNELS > 1) || (ch_q == 1'b0);
	assign period = time_q - rd_time;
	assign div_start = (state_q == ST_CALC) && in_range && (period != '0);
	assign st_wr = (state_q == ST_DIV) && div_stat.done;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_channel = out_ch_q;
	assign frequency = out_freq_q;
	assign updated = out_upd_q;

	cpfm_store #(
		.CHANNELS(CHANNELS),
		.IDX_W(IDX_W)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_idx(idx),
		.rd_time(rd_time),
		.rd_freq(rd_freq),
		.wr_en(st_wr),
		.wr_idx(idx),
		.wr_time(time_q),
		.wr_freq(quotient)
	);

	cpfm_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.rate(tick_rate_q),
		.divisor(period),
		.stat(div_stat),
		.quotient(quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tick_rate_q <= cpfm_pkg::TICK_RATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tick_rate_q <= cfg_wr_data;
			end
			if (state_q == ST_WAIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= div_start ? ST_DIV : ST_WAIT;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ch_q <= channel;
			time_q <= capture_time;
		end
		if (state_q == ST_CALC) begin
			res_freq_q <= in_range ? rd_freq : '0;
			res_upd_q <= 1'b0;
		end
		if (st_wr) begin
			res_freq_q <= quotient;
			res_upd_q <= 1'b1;
		end
		if (state_q == ST_WAIT && out_free) begin
			out_ch_q <= ch_q;
			out_freq_q <= res_freq_q;
			out_upd_q <= res_upd_q;
		end
	end

	`CPFM_ASSERT_NOW(a_done_in_div, clk, arst_n, div_stat.done, state_q == ST_DIV)
	`CPFM_ASSERT_NOW(a_start_idle_div, clk, arst_n, div_start, !div_stat.busy)
	`CPFM_ASSERT_NEXT(a_accept_calc, clk, arst_n, in_valid && !in_stall, state_q == ST_CALC)
	`CPFM_ASSERT_NOW(a_unused_chan, clk, arst_n, out_valid_q && CHANNELS < 2 && out_ch_q, out_freq_q == '0 && !out_upd_q)
endmodule

@@ test/tb_capture_period_frequency_meter_top.sv @@
// Testbench for the capture period frequency meter: random and directed captures, checked live.
`timescale 1ns / 1ps
module tb_capture_period_frequency_meter_top;
	localparam int TIME_W = cpfm_pkg::TIME_W;
	localparam int FREQ_W = cpfm_pkg::FREQ_W;
	localparam int RATE_W = cpfm_pkg::RATE_W;
	localparam int FRAC_BITS = cpfm_pkg::FRACTION_BITS_DEF;
	localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic ch;
		logic [TIME_W-1:0] stamp;
	} capture_t;

	typedef struct packed {
		logic ch;
		logic [FREQ_W-1:0] freq;
		logic upd;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic channel = 1'b0;
	logic [TIME_W-1:0] capture_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic out_channel;
	logic [FREQ_W-1:0] frequency;
	logic updated;
	logic cfg_wr_en = 1'b0;
	logic [RATE_W-1:0] cfg_wr_data = '0;

	capture_t pending_captures[$];
	reading_t expected_readings[$];
	capture_t next_capture;

	logic [RATE_W-1:0] tick_rate = cpfm_pkg::TICK_RATE_RESET;
	logic [TIME_W-1:0] stored_time[2];
	logic [FREQ_W-1:0] stored_freq[2];
	logic [TIME_W-1:0] sent_time[2];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_served = 0;
	int hold_left = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	int captures_taken = 0;
	int readings_checked = 0;
	int updates_seen = 0;
	int repeats_seen = 0;
	int rates_written = 0;
	bit capture_taken = 1'b0;

	capture_period_frequency_meter_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.channel(channel),
		.capture_time(capture_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_channel(out_channel),
		.frequency(frequency),
		.updated(updated),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		stored_time[0] = '0;
		stored_time[1] = '0;
		stored_freq[0] = '0;
		stored_freq[1] = '0;
		sent_time[0] = '0;
		sent_time[1] = '0;
	end

	task automatic report_mismatch(string msg);
		error_count++;
		$display("%0t: mismatch: %s", $time, msg);
	endtask

	function automatic reading_t measure_capture(capture_t c);
		reading_t r;
		logic [TIME_W-1:0] period;
		logic [63:0] scaled;
		logic [63:0] quot;
		period = c.stamp - stored_time[c.ch];
		r.ch = c.ch;
		r.upd = 1'b0;
		if (period != '0) begin
			scaled = 64'(tick_rate) << FRAC_BITS;
			quot = scaled / 64'(period);
			stored_freq[c.ch] = (quot > 64'(FREQ_MAX)) ? FREQ_MAX : quot[FREQ_W-1:0];
			stored_time[c.ch] = c.stamp;
			r.upd = 1'b1;
		end
		r.freq = stored_freq[c.ch];
		return r;
	endfunction

	// input acceptance, prediction, output check, watchdog
	always @(posedge clk) begin
		reading_t want;
		bit out_taken;
		capture_taken = arst_n && in_valid && !in_stall;
		out_taken = arst_n && (out_valid === 1'b1) && !out_stall;
		if (capture_taken) begin
			expected_readings.push_back(measure_capture('{ch: channel, stamp: capture_time}));
			captures_taken++;
		end
		if (out_taken) begin
			readings_checked++;
			if (expected_readings.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				want = expected_readings.pop_front();
				if (out_channel !== want.ch)
					report_mismatch($sformatf("out_channel %0b, want %0b", out_channel, want.ch));
				if (frequency !== want.freq)
					report_mismatch($sformatf("frequency %h, want %h (ch %0b)",
						frequency, want.freq, want.ch));
				if (updated !== want.upd)
					report_mismatch($sformatf("updated %0b, want %0b (ch %0b)",
						updated, want.upd, want.ch));
				if (want.upd)
					updates_seen++;
				else
					repeats_seen++;
			end
		end
		if (!arst_n || capture_taken || out_taken || cfg_wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("tb_capture_period_frequency_meter_top: errors");
			$finish;
		end
	end

	// sender
	always @(negedge clk) begin
		if (in_valid && !capture_taken) begin
			// hold the offered transaction
		end else if (pending_captures.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			next_capture = pending_captures.pop_front();
			in_valid <= 1'b1;
			channel <= next_capture.ch;
			capture_time <= next_capture.stamp;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req != hold_served) begin
			hold_served = hold_req;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic push_capture(logic ch, logic [TIME_W-1:0] stamp);
		pending_captures.push_back('{ch: ch, stamp: stamp});
		if (stamp != sent_time[ch])
			sent_time[ch] = stamp;
	endtask

	task automatic push_random_capture();
		logic ch;
		logic [TIME_W-1:0] stamp;
		int pick;
		ch = 1'($urandom_range(1, 0));
		pick = $urandom_range(99);
		if (pick < 15)
			stamp = sent_time[ch];
		else if (pick < 35)
			stamp = $urandom();
		else if (pick < 60)
			stamp = sent_time[ch] + $urandom_range(1000, 1);
		else if (pick < 85)
			stamp = sent_time[ch] + $urandom_range(5000000, 1000);
		else if (pick < 93)
			stamp = sent_time[ch] + $urandom();
		else
			stamp = sent_time[ch] - $urandom_range(64, 1);
		push_capture(ch, stamp);
	endtask

	task automatic wait_drained();
		while (pending_captures.size() > 0 || in_valid || expected_readings.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tick_rate(logic [RATE_W-1:0] rate);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= rate;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		tick_rate = rate;
		rates_written++;
	endtask

	task automatic run_phase(logic [RATE_W-1:0] rate, int idle, int stall, int count,
			bit long_hold);
		wait_drained();
		write_tick_rate(rate);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			push_random_capture();
		if (long_hold)
			hold_req++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first captures measured from zero, equal stamps, wraps, full periods
		push_capture(1'b0, 32'h0000_0000);
		push_capture(1'b1, 32'h0000_0000);
		push_capture(1'b0, 32'h0000_0001);
		push_capture(1'b0, 32'h0000_0001);
		push_capture(1'b0, 32'hFFFF_FFFF);
		push_capture(1'b0, 32'h0000_0000);
		push_capture(1'b1, 32'hFFFF_FFFF);
		push_capture(1'b1, 32'h0000_0003);
		push_capture(1'b1, 32'h8000_0003);
		push_capture(1'b0, 32'hAAAA_AAAA);
		push_capture(1'b0, 32'h5555_5555);
		push_capture(1'b1, 32'h8000_03EB);
		push_capture(1'b1, 32'h8000_03EB);

		wait_drained();
		write_tick_rate('1);
		push_capture(1'b0, 32'h5555_5556);
		push_capture(1'b1, 32'h8000_03EA);
		push_capture(1'b0, 32'h5555_5556);

		wait_drained();
		write_tick_rate(24'd1);
		push_capture(1'b0, 32'h5556_5556);
		push_capture(1'b0, 32'h5557_5557);
		push_capture(1'b0, 32'h5557_5558);
		push_capture(1'b1, 32'h8000_03E9);

		run_phase(cpfm_pkg::TICK_RATE_RESET, 0, 0, 300, 1'b0);
		run_phase('1, 75, 0, 300, 1'b0);
		run_phase(24'd1, 0, 75, 300, 1'b0);
		run_phase(RATE_W'($urandom_range(16777215, 1)), 8, 8, 300, 1'b0);
		run_phase(RATE_W'($urandom_range(2000000, 1000)), 0, 0, 300, 1'b1);
		run_phase(cpfm_pkg::TICK_RATE_RESET, 8, 8, 350, 1'b0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d captures on both channels, %0d tick rates incl. 1 and max",
			captures_taken, rates_written);
		$display("checked %0d results: %0d recomputed, %0d held; long output hold done",
			readings_checked, updates_seen, repeats_seen);
		if (error_count == 0 && expected_readings.size() == 0) begin
			$display("tb_capture_period_frequency_meter_top: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", error_count,
				expected_readings.size());
			$display("tb_capture_period_frequency_meter_top: errors");
		end
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/cpfm_pkg.sv
rtl/cpfm_div.sv
rtl/cpfm_store.sv
rtl/capture_period_frequency_meter_top.sv
test/tb_capture_period_frequency_meter_top.sv
